@@ design/fsts_pkg.sv @@
// Shared types, codes and constants for the four-slot thread scheduler.
package fsts_pkg;

    // Item kinds
    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_EXIT   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Slot layout and timing constants
    localparam int unsigned STACK_STRIDE  = 16;
    localparam int unsigned STACK_BASE    = 'h3F;
    localparam int unsigned CONTEXT_BYTES = 7;
    localparam logic [3:0]  FULL_MASK     = 4'hF;
    localparam logic [7:0]  TICKS_RESET   = 8'd30;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // commit state and load the result register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;  // result register full and not taken this cycle
    } t_dp_status;

    // Initial saved stack pointer of a freshly created slot (wraps at 256)
    function automatic logic [7:0] init_stack_ptr(input logic [1:0] slot);
        logic [15:0] v;
        v = 16'(STACK_BASE) + 16'(STACK_STRIDE) * {14'd0, slot} + 16'(CONTEXT_BYTES);
        return v[7:0];
    endfunction

endpackage

@@ design/fsts_ctrl.sv @@
// Controller state machine for the four-slot thread scheduler.
module fsts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fsts_pkg::t_dp_status  i_status,
    output fsts_pkg::t_ctrl_cmd   o_cmd
);

    fsts_pkg::t_state r_state;
    fsts_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            fsts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = fsts_pkg::ST_EXEC;
                end
            end
            fsts_pkg::ST_EXEC: begin
                // wait here while the previous result is still held
                if (!i_status.out_busy) begin
                    o_cmd.execute = 1'b1;
                    n_state       = fsts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/fsts_datapath.sv @@
// Datapath: slot mask, running slot, saved stack pointers, prescaler, result register.
module fsts_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsts_pkg::t_ctrl_cmd  i_cmd,
    output fsts_pkg::t_dp_status o_status,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_ticks_per_time_unit,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_current_stack_ptr,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_created_slot,
    output logic                 o_create_refused,
    output logic [4:0]           o_bank_status,
    output logic [1:0]           o_next_slot,
    output logic [7:0]           o_restore_stack_ptr,
    output logic                 o_none_runnable,
    output logic [7:0]           o_time_count
);

    // Scheduler state
    logic [3:0] r_mask;
    logic [1:0] r_running;
    logic [7:0] r_saved_sp [4];
    logic [7:0] r_prescale;
    logic [7:0] r_ctime;
    logic [7:0] r_tpu;

    // Captured transaction
    logic [1:0] r_kind;
    logic [7:0] r_sp;

    // Result register
    logic       r_out_valid;
    logic [1:0] r_created_slot;
    logic       r_create_refused;
    logic [4:0] r_bank_status;
    logic [1:0] r_next_slot;
    logic [7:0] r_restore_sp;
    logic       r_none_runnable;
    logic [7:0] r_time_count;

    // Next values
    logic [3:0] n_mask;
    logic [1:0] n_running;
    logic [7:0] n_prescale;
    logic [7:0] n_ctime;
    logic [1:0] n_created_slot;
    logic       n_create_refused;
    logic [4:0] n_bank_status;
    logic [1:0] n_next_slot;
    logic [7:0] n_restore_sp;
    logic       n_none_runnable;

    logic       sp_wr_en;
    logic [1:0] sp_wr_addr;
    logic [7:0] sp_wr_data;

    logic [1:0] free_slot;
    logic [3:0] rot_mask;
    logic [1:0] pick_slot;
    logic       pick_found;
    logic [1:0] cand;
    logic [7:0] prescale_inc;

    // Lowest free slot
    always_comb begin
        free_slot = 2'd3;
        for (int s = 3; s >= 0; s--) begin
            if (!r_mask[s]) begin
                free_slot = 2'(s);
            end
        end
    end

    // Mask seen by the rotation: exit drops the running slot first
    assign rot_mask = (r_kind == fsts_pkg::KIND_EXIT) ? (r_mask & ~(4'b0001 << r_running))
                                                     : r_mask;

    // Round-robin pick, the running slot itself tried last
    always_comb begin
        pick_found = 1'b0;
        pick_slot  = r_running;
        cand       = r_running;
        for (int k = 1; k <= 4; k++) begin
            cand = r_running + 2'(k);
            if (!pick_found && rot_mask[cand]) begin
                pick_found = 1'b1;
                pick_slot  = cand;
            end
        end
    end

    assign prescale_inc = r_prescale + 8'd1;

    // Item evaluation
    always_comb begin
        n_mask           = r_mask;
        n_running        = r_running;
        n_prescale       = r_prescale;
        n_ctime          = r_ctime;
        n_created_slot   = 2'd0;
        n_create_refused = 1'b0;
        n_bank_status    = 5'd0;
        n_next_slot      = 2'd0;
        n_restore_sp     = 8'd0;
        n_none_runnable  = 1'b0;
        sp_wr_en         = 1'b0;
        sp_wr_addr       = r_running;
        sp_wr_data       = r_sp;
        unique case (r_kind)
            fsts_pkg::KIND_CREATE: begin
                if (r_mask == fsts_pkg::FULL_MASK) begin
                    n_create_refused = 1'b1;
                end else begin
                    n_mask         = r_mask | (4'b0001 << free_slot);
                    sp_wr_en       = 1'b1;
                    sp_wr_addr     = free_slot;
                    sp_wr_data     = fsts_pkg::init_stack_ptr(free_slot);
                    n_created_slot = free_slot;
                    n_bank_status  = {free_slot, 3'b000};
                end
            end
            fsts_pkg::KIND_EXIT, fsts_pkg::KIND_TICK: begin
                n_mask = rot_mask;
                if (r_kind == fsts_pkg::KIND_TICK) begin
                    sp_wr_en = 1'b1;
                    if (prescale_inc == r_tpu) begin
                        n_prescale = 8'd0;
                        n_ctime    = r_ctime + 8'd1;
                    end else begin
                        n_prescale = prescale_inc;
                    end
                end
                if (pick_found) begin
                    n_running   = pick_slot;
                    n_next_slot = pick_slot;
                    // bypass the stack pointer saved by this same tick
                    if (r_kind == fsts_pkg::KIND_TICK && pick_slot == r_running) begin
                        n_restore_sp = r_sp;
                    end else begin
                        n_restore_sp = r_saved_sp[pick_slot];
                    end
                end else begin
                    n_none_runnable = 1'b1;
                end
            end
            default: begin
                // unknown kind: no state change, only the time count is reported
            end
        endcase
    end

    // Capture of the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_sp   <= i_current_stack_ptr;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= 4'd0;
            r_running  <= 2'd0;
            r_prescale <= 8'd0;
            r_ctime    <= 8'd0;
            r_tpu      <= fsts_pkg::TICKS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_tpu <= i_cfg_ticks_per_time_unit;
            end
            if (i_cmd.execute) begin
                r_mask     <= n_mask;
                r_running  <= n_running;
                r_prescale <= n_prescale;
                r_ctime    <= n_ctime;
            end
        end
    end

    // Saved stack pointers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && sp_wr_en) begin
            r_saved_sp[sp_wr_addr] <= sp_wr_data;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_created_slot   <= n_created_slot;
            r_create_refused <= n_create_refused;
            r_bank_status    <= n_bank_status;
            r_next_slot      <= n_next_slot;
            r_restore_sp     <= n_restore_sp;
            r_none_runnable  <= n_none_runnable;
            r_time_count     <= n_ctime;
        end
    end

    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_created_slot      = r_created_slot;
    assign o_create_refused    = r_create_refused;
    assign o_bank_status       = r_bank_status;
    assign o_next_slot         = r_next_slot;
    assign o_restore_stack_ptr = r_restore_sp;
    assign o_none_runnable     = r_none_runnable;
    assign o_time_count        = r_time_count;

endmodule

@@ design/four_slot_thread_scheduler_unit.sv @@
// Top level of the four-slot round-robin thread scheduler.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready    i_kind, i_current_stack_ptr
//   out      output     o_out_valid / i_out_ready  o_created_slot .. o_time_count
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_ticks_per_time_unit
//
// Each transaction is latched by the capture register, then evaluated and committed
// by the single evaluation stage of the datapath, which loads the result register.
// The result register holds one result; a new transaction is accepted while it waits,
// but its commit stalls until the held result is taken.
// Synchronous active-low reset clears slot mask, running slot, prescaler and time count
// and loads 30 ticks per time unit; saved stack pointers are not reset.
module four_slot_thread_scheduler_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_current_stack_ptr,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_created_slot,
    output logic       o_create_refused,
    output logic [4:0] o_bank_status,
    output logic [1:0] o_next_slot,
    output logic [7:0] o_restore_stack_ptr,
    output logic       o_none_runnable,
    output logic [7:0] o_time_count,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_ticks_per_time_unit
);

    fsts_pkg::t_ctrl_cmd  cmd;
    fsts_pkg::t_dp_status status;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    fsts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fsts_datapath u_dp (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cmd                     (cmd),
        .o_status                  (status),
        .i_cfg_valid               (i_cfg_valid),
        .i_cfg_ticks_per_time_unit (i_cfg_ticks_per_time_unit),
        .i_kind                    (i_kind),
        .i_current_stack_ptr       (i_current_stack_ptr),
        .o_out_valid               (o_out_valid),
        .i_out_ready               (i_out_ready),
        .o_created_slot            (o_created_slot),
        .o_create_refused          (o_create_refused),
        .o_bank_status             (o_bank_status),
        .o_next_slot               (o_next_slot),
        .o_restore_stack_ptr       (o_restore_stack_ptr),
        .o_none_runnable           (o_none_runnable),
        .o_time_count              (o_time_count)
    );

endmodule

@@ design/fsts_checker.sv @@
// Port-level checker for the four-slot thread scheduler, bound to the top level.
module fsts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_created_slot,
    input logic       o_create_refused,
    input logic [4:0] o_bank_status,
    input logic [1:0] o_next_slot,
    input logic [7:0] o_restore_stack_ptr,
    input logic       o_none_runnable,
    input logic [7:0] o_time_count
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_slot)
            && $stable(o_restore_stack_ptr) && $stable(o_time_count))
        else $error("result changed while stalled");

    // One transaction in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // Bank status follows the created slot
    a_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bank_status == {o_created_slot, 3'b000})
        else $error("bank status does not match created slot");

    // A refused create reports nothing else
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_create_refused |-> o_created_slot == 2'd0
            && o_next_slot == 2'd0 && !o_none_runnable)
        else $error("refused create carries other fields");

    // Nothing runnable gives an empty pick
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_runnable |-> o_next_slot == 2'd0
            && o_restore_stack_ptr == 8'd0 && !o_create_refused)
        else $error("empty pick carries a slot");

endmodule

bind four_slot_thread_scheduler_unit fsts_checker u_fsts_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for the four-slot thread scheduler: predicted results against the DUT.
`timescale 1ns / 1ps

module tb;

    // Encoding the block treats as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] stack_ptr;
    } t_sched_item;

    typedef struct packed {
        logic [1:0] created_slot;
        logic       create_refused;
        logic [4:0] bank_status;
        logic [1:0] next_slot;
        logic [7:0] restore_stack_ptr;
        logic       none_runnable;
        logic [7:0] time_count;
    } t_sched_result;

    // DUT connections, every driven input known from time zero
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] in_kind = 2'd0;
    logic [7:0] in_stack_ptr = 8'd0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_ticks = 8'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_created_slot;
    logic       o_create_refused;
    logic [4:0] o_bank_status;
    logic [1:0] o_next_slot;
    logic [7:0] o_restore_stack_ptr;
    logic       o_none_runnable;
    logic [7:0] o_time_count;
    logic       o_cfg_ready;

    // Scheduler shadow state
    logic [3:0] slots_in_use;
    logic [1:0] cur_slot;
    logic [7:0] slot_stack_ptr [4];
    logic [7:0] prescale_cnt;
    logic [7:0] coarse_cnt;
    logic [7:0] ticks_per_unit;

    t_sched_item   pending_items [$];
    t_sched_result expected_results [$];
    t_sched_item   drv_item;
    t_sched_result exp_res;

    int n_accepted = 0;
    int n_checked  = 0;
    int errors     = 0;
    int hold_left  = 0;
    int holds_done = 0;
    logic calm;

    four_slot_thread_scheduler_unit i_dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_in_valid                (in_valid),
        .o_in_ready                (o_in_ready),
        .i_kind                    (in_kind),
        .i_current_stack_ptr       (in_stack_ptr),
        .o_out_valid               (o_out_valid),
        .i_out_ready               (out_ready),
        .o_created_slot            (o_created_slot),
        .o_create_refused          (o_create_refused),
        .o_bank_status             (o_bank_status),
        .o_next_slot               (o_next_slot),
        .o_restore_stack_ptr       (o_restore_stack_ptr),
        .o_none_runnable           (o_none_runnable),
        .o_time_count              (o_time_count),
        .i_cfg_valid               (cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_ticks_per_time_unit (cfg_ticks)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // No idling on either side for a stretch in the middle of the run
    assign calm = (n_accepted >= 300) && (n_accepted < 550);

    // Work out the result of one transaction and advance the shadow state
    function automatic t_sched_result sched_predict(input logic [1:0] kind,
                                                    input logic [7:0] stack_ptr);
        t_sched_result r;
        logic [1:0]    s;
        logic [1:0]    pick;
        logic          found;
        int            k;
        r = '0;
        s = 2'd0;
        pick = cur_slot;
        found = 1'b0;
        case (kind)
            fsts_pkg::KIND_CREATE: begin
                if (slots_in_use == fsts_pkg::FULL_MASK) begin
                    r.create_refused = 1'b1;
                end else begin
                    // lowest free slot
                    for (k = 3; k >= 0; k--)
                        if (!slots_in_use[k]) s = 2'(k);
                    slots_in_use[s] = 1'b1;
                    slot_stack_ptr[s] = 8'(fsts_pkg::STACK_BASE
                        + fsts_pkg::STACK_STRIDE * s + fsts_pkg::CONTEXT_BYTES);
                    r.created_slot = s;
                    r.bank_status = {s, 3'b000};
                end
            end
            fsts_pkg::KIND_EXIT, fsts_pkg::KIND_TICK: begin
                if (kind == fsts_pkg::KIND_EXIT) begin
                    slots_in_use[cur_slot] = 1'b0;
                end else begin
                    slot_stack_ptr[cur_slot] = stack_ptr;
                    prescale_cnt = prescale_cnt + 8'd1;
                    if (prescale_cnt == ticks_per_unit) begin
                        prescale_cnt = 8'd0;
                        coarse_cnt = coarse_cnt + 8'd1;
                    end
                end
                // rotation: the running slot itself is tried last
                for (k = 1; k <= 4; k++) begin
                    s = cur_slot + 2'(k);
                    if (!found && slots_in_use[s]) begin
                        found = 1'b1;
                        pick = s;
                    end
                end
                if (found) begin
                    cur_slot = pick;
                    r.next_slot = pick;
                    r.restore_stack_ptr = slot_stack_ptr[pick];
                end else begin
                    r.none_runnable = 1'b1;
                end
            end
            default: ;
        endcase
        r.time_count = coarse_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    // Driver: offers queued transactions, predicting each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(sched_predict(in_kind, in_stack_ptr));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                    drv_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_kind <= drv_item.kind;
                    in_stack_ptr <= drv_item.stack_ptr;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering, to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && n_checked >= (holds_done == 0 ? 200 : 700)
                     && pending_items.size() > 40) begin
            hold_left <= 80;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: compares each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time,
                             {o_created_slot, o_create_refused, o_bank_status, o_next_slot,
                              o_restore_stack_ptr, o_none_runnable, o_time_count});
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("created_slot", exp_res.created_slot, o_created_slot);
                    check_field("create_refused", exp_res.create_refused, o_create_refused);
                    check_field("bank_status", exp_res.bank_status, o_bank_status);
                    check_field("next_slot", exp_res.next_slot, o_next_slot);
                    check_field("restore_stack_ptr", exp_res.restore_stack_ptr,
                                o_restore_stack_ptr);
                    check_field("none_runnable", exp_res.none_runnable, o_none_runnable);
                    check_field("time_count", exp_res.time_count, o_time_count);
                end
                n_checked <= n_checked + 1;
            end
            out_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 10);
        end
    end

    task automatic push_item(input logic [1:0] kind, input logic [7:0] stack_ptr);
        t_sched_item it;
        it.kind = kind;
        it.stack_ptr = stack_ptr;
        pending_items.push_back(it);
    endtask

    // Random transactions; whatever is left after create, exit and tick is the unused kind
    task automatic queue_random(input int n, input int create_pct, input int exit_pct,
                                input int tick_pct);
        int         r;
        logic [1:0] kind;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < create_pct)
                kind = fsts_pkg::KIND_CREATE;
            else if (r < create_pct + exit_pct)
                kind = fsts_pkg::KIND_EXIT;
            else if (r < create_pct + exit_pct + tick_pct)
                kind = fsts_pkg::KIND_TICK;
            else
                kind = KIND_UNUSED;
            push_item(kind, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write, only ever issued while the block is idle
    task automatic write_ticks(input logic [7:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_ticks <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ticks_per_unit = value;
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        slots_in_use = 4'd0;
        cur_slot = 2'd0;
        prescale_cnt = 8'd0;
        coarse_cnt = 8'd0;
        ticks_per_unit = fsts_pkg::TICKS_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty scheduler, filling up, refusal, rotation, exits to empty
        push_item(fsts_pkg::KIND_TICK, 8'hFF);
        push_item(fsts_pkg::KIND_EXIT, 8'h00);
        push_item(KIND_UNUSED, 8'hAA);
        repeat (4) push_item(fsts_pkg::KIND_CREATE, 8'h00);
        push_item(fsts_pkg::KIND_CREATE, 8'hFF);
        push_item(fsts_pkg::KIND_TICK, 8'h00);
        push_item(fsts_pkg::KIND_TICK, 8'hFF);
        push_item(fsts_pkg::KIND_TICK, 8'h55);
        push_item(fsts_pkg::KIND_TICK, 8'hAA);
        push_item(fsts_pkg::KIND_TICK, 8'h81);
        push_item(fsts_pkg::KIND_EXIT, 8'h00);
        push_item(fsts_pkg::KIND_CREATE, 8'h00);
        push_item(KIND_UNUSED, 8'hFF);
        repeat (4) push_item(fsts_pkg::KIND_EXIT, 8'h00);
        push_item(fsts_pkg::KIND_EXIT, 8'h00);
        push_item(fsts_pkg::KIND_TICK, 8'h12);
        push_item(fsts_pkg::KIND_CREATE, 8'h00);
        push_item(fsts_pkg::KIND_TICK, 8'h7E);
        push_item(fsts_pkg::KIND_EXIT, 8'hFF);
        wait_idle();

        // one tick per time unit; the earlier ticks leave the prescaler above that, so it must wrap first
        write_ticks(8'd1);
        queue_random(150, 40, 20, 35);
        wait_idle();

        // slowest prescaler, tick heavy so the prescaler climbs high
        write_ticks(8'd255);
        queue_random(300, 20, 10, 65);
        wait_idle();

        // prescaler now above the setting: it must count through the wrap
        write_ticks(8'd1);
        queue_random(200, 15, 10, 70);
        wait_idle();

        write_ticks(8'($urandom_range(1, 255)));
        queue_random(200, 30, 30, 35);
        wait_idle();

        write_ticks(8'd128);
        queue_random(200, 35, 25, 35);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        if (errors == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ four_slot_thread_scheduler_unit.f @@
design/fsts_pkg.sv
design/fsts_ctrl.sv
design/fsts_datapath.sv
design/four_slot_thread_scheduler_unit.sv
design/fsts_checker.sv
bench/tb.sv
